@@ rtl/core/gelu_pkg.sv @@
// Shared constants, types and table-generation math for the GELU block.
`default_nettype none

package gelu_pkg;

  localparam int DATA_W = 16;
  localparam int WGT_W = 15;
  localparam int TAB_W = 31;
  localparam int CDF_W = TAB_W + 1;
  localparam int G_W = 48;
  localparam int LO_W = 24;
  localparam int V_W = 64;
  localparam int Q_SHIFT = 30;
  localparam int STAGES = 10;
  localparam int SUBSTEPS = 16;
  localparam int EXP_TERMS = 20;
  localparam int EXP_CUTOFF = 40;

  localparam int FRAC_BITS_DEF = 12;
  localparam int TABLE_SEGMENTS_DEF = 256;

  localparam longint unsigned Q30_ONE = 64'd1 << Q_SHIFT;
  localparam longint unsigned INV_SQRT_2PI_Q30 = 64'd428361012;

  typedef logic [STAGES-1:0] stage_en_t;

  typedef enum logic {
    ACT_FORWARD  = 1'b0,
    ACT_BACKWARD = 1'b1
  } action_t;

  function automatic longint unsigned exp_series(input longint unsigned f);
    longint signed sum;
    longint unsigned mag;
    sum = longint'(Q30_ONE);
    mag = Q30_ONE;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      mag = ((mag * f) >> Q_SHIFT) / 64'(k);
      if (k[0]) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    return (sum > 0) ? 64'(sum) : 64'd0;
  endfunction

  localparam longint unsigned E1_Q30 = exp_series(Q30_ONE);

  function automatic longint unsigned exp_neg(input longint unsigned u);
    longint unsigned n;
    longint unsigned r;
    if (u >= (64'(EXP_CUTOFF) << Q_SHIFT)) begin
      return 64'd0;
    end
    n = u >> Q_SHIFT;
    r = exp_series(u & (Q30_ONE - 64'd1));
    for (int i = 0; i < EXP_CUTOFF; i++) begin
      if (64'(i) < n) begin
        r = (r * E1_Q30 + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gelu_ctrl.sv @@
// Valid tracking and per-stage load enables for the GELU pipeline.
`default_nettype none

module gelu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output gelu_pkg::stage_en_t    en
);
  import gelu_pkg::*;

  stage_en_t vld;
  stage_en_t rdy;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign en       = rdy;
  assign s_tready = rdy[0];
  assign m_tvalid = vld[STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/gelu_lookup.sv @@
// Magnitude indexing, cdf/pdf table lookup and linear interpolation.
`default_nettype none

module gelu_lookup #(
  parameter int FRAC_BITS      = gelu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_SEGMENTS = gelu_pkg::TABLE_SEGMENTS_DEF
) (
  input  wire logic                                clk,
  input  wire gelu_pkg::stage_en_t                 en,
  input  wire logic                                action,
  input  wire logic signed [gelu_pkg::DATA_W-1:0]  x_value,
  input  wire logic signed [gelu_pkg::DATA_W-1:0]  grad_in,
  output logic                                     s3_action,
  output logic signed [gelu_pkg::DATA_W-1:0]       s3_x,
  output logic signed [gelu_pkg::DATA_W-1:0]       s3_dy,
  output logic signed [gelu_pkg::CDF_W-1:0]        s3_cdf,
  output logic [gelu_pkg::TAB_W-1:0]               s3_pdf
);
  import gelu_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SEGMENTS + 1);
  localparam int P_W = DATA_W + IDX_W;
  localparam int PRD_W = TAB_W + WGT_W + 1;
  localparam int SUM_W = PRD_W + 1;
  localparam longint unsigned FINE_POINTS = 64'(TABLE_SEGMENTS) * 64'(SUBSTEPS);
  localparam longint unsigned SIMPSON_DEN = 64'd3 * FINE_POINTS;

  typedef logic [TAB_W-1:0] tab_t [0:TABLE_SEGMENTS];

  function automatic longint unsigned pdf_at(input longint unsigned j);
    longint unsigned pos;
    longint unsigned u;
    pos = (j << (35 - FRAC_BITS)) / FINE_POINTS;
    u = (pos * pos) >> 11;
    return (exp_neg(u) * INV_SQRT_2PI_Q30 + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
  endfunction

  function automatic tab_t build_tab(input logic want_cdf);
    tab_t t;
    longint unsigned acc;
    longint unsigned wsum;
    longint unsigned wt;
    acc = Q30_ONE >> 1;
    t[0] = want_cdf ? TAB_W'(acc) : TAB_W'(pdf_at(64'd0));
    for (int i = 0; i < TABLE_SEGMENTS; i++) begin
      if (want_cdf) begin
        wsum = 64'd0;
        for (int k = 0; k <= SUBSTEPS; k++) begin
          if (k == 0 || k == SUBSTEPS) begin
            wt = 64'd1;
          end else if (k[0]) begin
            wt = 64'd4;
          end else begin
            wt = 64'd2;
          end
          wsum = wsum + wt * pdf_at(64'(i * SUBSTEPS + k));
        end
        acc = acc + ((wsum << (15 - FRAC_BITS)) + SIMPSON_DEN / 2) / SIMPSON_DEN;
        if (acc > Q30_ONE) begin
          acc = Q30_ONE;
        end
        t[i+1] = TAB_W'(acc);
      end else begin
        t[i+1] = TAB_W'(pdf_at(64'((i + 1) * SUBSTEPS)));
      end
    end
    return t;
  endfunction

  localparam tab_t CDF_TAB = build_tab(1'b1);
  localparam tab_t PDF_TAB = build_tab(1'b0);

  logic [DATA_W-1:0]        mag_in;
  logic [P_W-1:0]           pos_in;

  logic                     s0_action;
  logic signed [DATA_W-1:0] s0_x;
  logic signed [DATA_W-1:0] s0_dy;
  logic [IDX_W-1:0]         s0_idx;
  logic [IDX_W-1:0]         s0_idx1;
  logic [WGT_W-1:0]         s0_w;

  logic                     s1_action;
  logic signed [DATA_W-1:0] s1_x;
  logic signed [DATA_W-1:0] s1_dy;
  logic [WGT_W-1:0]         s1_w;
  logic [WGT_W:0]           s1_wc;
  logic [TAB_W-1:0]         s1_c0;
  logic [TAB_W-1:0]         s1_c1;
  logic [TAB_W-1:0]         s1_p0;
  logic [TAB_W-1:0]         s1_p1;

  logic                     s2_action;
  logic signed [DATA_W-1:0] s2_x;
  logic signed [DATA_W-1:0] s2_dy;
  logic [PRD_W-1:0]         s2_pc0;
  logic [PRD_W-1:0]         s2_pc1;
  logic [PRD_W-1:0]         s2_pp0;
  logic [PRD_W-1:0]         s2_pp1;

  logic [SUM_W-1:0]         sum_c;
  logic [SUM_W-1:0]         sum_p;
  logic [TAB_W-1:0]         c_mag;

  assign mag_in = x_value[DATA_W-1] ? DATA_W'(-x_value) : DATA_W'(x_value);
  assign pos_in = P_W'(mag_in) * P_W'(TABLE_SEGMENTS);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_action <= action;
      s0_x      <= x_value;
      s0_dy     <= grad_in;
      s0_idx    <= pos_in[WGT_W +: IDX_W];
      s0_w      <= pos_in[WGT_W-1:0];
    end
  end

  assign s0_idx1 = (s0_idx == IDX_W'(TABLE_SEGMENTS)) ? s0_idx : s0_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_action <= s0_action;
      s1_x      <= s0_x;
      s1_dy     <= s0_dy;
      s1_w      <= s0_w;
      s1_c0     <= CDF_TAB[s0_idx];
      s1_c1     <= CDF_TAB[s0_idx1];
      s1_p0     <= PDF_TAB[s0_idx];
      s1_p1     <= PDF_TAB[s0_idx1];
    end
  end

  assign s1_wc = {1'b1, {WGT_W{1'b0}}} - {1'b0, s1_w};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_action <= s1_action;
      s2_x      <= s1_x;
      s2_dy     <= s1_dy;
      s2_pc0    <= PRD_W'(s1_c0) * PRD_W'(s1_wc);
      s2_pc1    <= PRD_W'(s1_c1) * PRD_W'(s1_w);
      s2_pp0    <= PRD_W'(s1_p0) * PRD_W'(s1_wc);
      s2_pp1    <= PRD_W'(s1_p1) * PRD_W'(s1_w);
    end
  end

  assign sum_c = SUM_W'(s2_pc0) + SUM_W'(s2_pc1) + (SUM_W'(1) << (WGT_W - 1));
  assign sum_p = SUM_W'(s2_pp0) + SUM_W'(s2_pp1) + (SUM_W'(1) << (WGT_W - 1));
  assign c_mag = sum_c[WGT_W +: TAB_W];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_action <= s2_action;
      s3_x      <= s2_x;
      s3_dy     <= s2_dy;
      s3_pdf    <= sum_p[WGT_W +: TAB_W];
      s3_cdf    <= s2_x[DATA_W-1] ? signed'({1'b0, TAB_W'(Q30_ONE) - c_mag})
                                  : signed'({1'b0, c_mag});
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gelu_product.sv @@
// Forward and backward products, rounding to nearest and saturation.
`default_nettype none

module gelu_product #(
  parameter int FRAC_BITS = gelu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire gelu_pkg::stage_en_t                 en,
  input  wire logic                                s3_action,
  input  wire logic signed [gelu_pkg::DATA_W-1:0]  s3_x,
  input  wire logic signed [gelu_pkg::DATA_W-1:0]  s3_dy,
  input  wire logic signed [gelu_pkg::CDF_W-1:0]   s3_cdf,
  input  wire logic [gelu_pkg::TAB_W-1:0]          s3_pdf,
  output logic [gelu_pkg::DATA_W-1:0]              result_value,
  output logic                                     saturated
);
  import gelu_pkg::*;

  localparam int ML_W = DATA_W + LO_W + 1;
  localparam int MH_W = DATA_W + G_W - LO_W;
  localparam int SH_F = Q_SHIFT;
  localparam int SH_B = Q_SHIFT + FRAC_BITS;
  localparam int RND_W = V_W - Q_SHIFT;
  localparam logic [RND_W-1:0] POS_MAX = RND_W'(32767);
  localparam logic [RND_W-1:0] NEG_MAX = RND_W'(32768);

  logic                     s4_action;
  logic signed [DATA_W-1:0] s4_dy;
  logic signed [CDF_W-1:0]  s4_cdf;
  logic signed [G_W-1:0]    s4_xcdf;
  logic signed [G_W-1:0]    s4_xd;

  logic                     s5_action;
  logic signed [DATA_W-1:0] s5_dy;
  logic signed [G_W-1:0]    s5_xcdf;
  logic signed [G_W-1:0]    s5_g;

  logic                     s6_action;
  logic signed [G_W-1:0]    s6_xcdf;
  logic signed [ML_W-1:0]   s6_mlo;
  logic signed [MH_W-1:0]   s6_mhi;

  logic                     s7_action;
  logic signed [V_W-1:0]    s7_v;

  logic                     s8_neg;
  logic [RND_W-1:0]         s8_rnd;

  logic                     v_neg;
  logic [V_W-1:0]           v_mag;
  logic [V_W-1:0]           v_sum;
  logic [V_W-1:0]           v_shr;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_action <= s3_action;
      s4_dy     <= s3_dy;
      s4_cdf    <= s3_cdf;
      s4_xcdf   <= G_W'(s3_x) * G_W'(s3_cdf);
      s4_xd     <= G_W'(s3_x) * G_W'(signed'({1'b0, s3_pdf}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_action <= s4_action;
      s5_dy     <= s4_dy;
      s5_xcdf   <= s4_xcdf;
      s5_g      <= (G_W'(s4_cdf) <<< FRAC_BITS) + s4_xd;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_action <= s5_action;
      s6_xcdf   <= s5_xcdf;
      s6_mlo    <= ML_W'(s5_dy) * ML_W'(signed'({1'b0, s5_g[LO_W-1:0]}));
      s6_mhi    <= MH_W'(s5_dy) * MH_W'(signed'(s5_g[G_W-1:LO_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_action <= s6_action;
      s7_v      <= (s6_action == ACT_BACKWARD) ?
                   (V_W'(s6_mhi) <<< LO_W) + V_W'(s6_mlo) : V_W'(s6_xcdf);
    end
  end

  assign v_neg = s7_v[V_W-1];
  assign v_mag = v_neg ? V_W'(-s7_v) : V_W'(s7_v);
  assign v_sum = v_mag + ((s7_action == ACT_BACKWARD) ? (V_W'(1) << (SH_B - 1))
                                                      : (V_W'(1) << (SH_F - 1)));
  assign v_shr = (s7_action == ACT_BACKWARD) ? (v_sum >> SH_B) : (v_sum >> SH_F);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_neg <= v_neg;
      s8_rnd <= v_shr[RND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      priority if (!s8_neg && s8_rnd > POS_MAX) begin
        result_value <= DATA_W'(32767);
        saturated    <= 1'b1;
      end else if (s8_neg && s8_rnd > NEG_MAX) begin
        result_value <= DATA_W'(32768);
        saturated    <= 1'b1;
      end else begin
        result_value <= s8_neg ? DATA_W'(0) - s8_rnd[DATA_W-1:0] : s8_rnd[DATA_W-1:0];
        saturated    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gelu_forward_backward.sv @@
// Top level of the GELU forward/backward stream block.
//
//   channel  dir  tdata                               tuser
//   s_       in   [15:0] x_value, [31:16] grad_in     [0] action
//   m_       out  [15:0] result_value                 [0] saturated
//
// Ten register stages: index, table read, interpolation products, cdf/pdf,
// x products, gradient term, split dy product, combine, round, saturate.
// One item per cycle unless m_tready stalls; m_tvalid is the saturate stage's valid.
// Each stage loads when it is empty or the stage after it moves, so empty
// stages fill up while the output waits and no item is lost or repeated.
// Synchronous reset clears only the valid bits; tables are constants.
`default_nettype none

module gelu_forward_backward #(
  parameter int FRAC_BITS      = gelu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_SEGMENTS = gelu_pkg::TABLE_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // x_value, grad_in
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // result_value
  output logic             m_tuser    // saturated
);
  import gelu_pkg::*;

  stage_en_t                en;
  logic                     s3_action;
  logic signed [DATA_W-1:0] s3_x;
  logic signed [DATA_W-1:0] s3_dy;
  logic signed [CDF_W-1:0]  s3_cdf;
  logic [TAB_W-1:0]         s3_pdf;

  gelu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .en       (en)
  );

  gelu_lookup #(
    .FRAC_BITS      (FRAC_BITS),
    .TABLE_SEGMENTS (TABLE_SEGMENTS)
  ) u_lookup (
    .clk       (clk),
    .en        (en),
    .action    (s_tuser),
    .x_value   (signed'(s_tdata[DATA_W-1:0])),
    .grad_in   (signed'(s_tdata[2*DATA_W-1:DATA_W])),
    .s3_action (s3_action),
    .s3_x      (s3_x),
    .s3_dy     (s3_dy),
    .s3_cdf    (s3_cdf),
    .s3_pdf    (s3_pdf)
  );

  gelu_product #(
    .FRAC_BITS (FRAC_BITS)
  ) u_product (
    .clk          (clk),
    .en           (en),
    .s3_action    (s3_action),
    .s3_x         (s3_x),
    .s3_dy        (s3_dy),
    .s3_cdf       (s3_cdf),
    .s3_pdf       (s3_pdf),
    .result_value (m_tdata),
    .saturated    (m_tuser)
  );

endmodule

`default_nettype wire

@@ sim/gelu_forward_backward_check.sv @@
// Channel monitor for the GELU stream block: predicts every result and compares it on arrival.
module gelu_forward_backward_check
  import gelu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // x_value, grad_in
  input  logic        s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // result_value
  input  logic        m_tuser,   // saturated
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SEGS = TABLE_SEGMENTS_DEF;
  localparam int FINE = SEGS * SUBSTEPS;

  typedef struct packed {
    logic [15:0] result_value;
    logic        saturated;
  } gelu_result_t;

  longint unsigned cdf_q30 [0:SEGS];
  longint unsigned pdf_q30 [0:SEGS];
  longint unsigned e1_q30;
  gelu_result_t    expected_results [$];
  int              mismatch_total = 0;
  int              outstanding = 0;

  assign failures = mismatch_total;
  assign pending  = outstanding;

  function automatic longint unsigned exp_taylor(input longint unsigned f);
    longint signed   sum;
    longint unsigned mag;
    sum = longint'(Q30_ONE);
    mag = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      mag = ((mag * f) >> 30) / longint'(k);
      if (k % 2 == 1) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    return (sum > 0) ? longint'(sum) : 64'd0;
  endfunction

  function automatic longint unsigned gauss_density(input longint unsigned j);
    longint unsigned pos, u, n, e;
    pos = (j << (35 - FRAC)) / longint'(FINE);
    u   = (pos * pos) >> 11;
    if (u >= (64'd40 << 30)) begin
      e = 64'd0;
    end else begin
      n = u >> 30;
      e = exp_taylor(u & (Q30_ONE - 64'd1));
      for (longint unsigned i = 0; i < n; i++) begin
        e = (e * e1_q30 + (64'd1 << 29)) >> 30;
      end
    end
    return (e * INV_SQRT_2PI_Q30 + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned table_lerp(input bit use_pdf, input longint unsigned idx,
                                                 input longint unsigned w);
    longint unsigned lo, hi;
    if (idx >= SEGS) begin
      return use_pdf ? pdf_q30[SEGS] : cdf_q30[SEGS];
    end
    lo = use_pdf ? pdf_q30[idx] : cdf_q30[idx];
    hi = use_pdf ? pdf_q30[idx + 1] : cdf_q30[idx + 1];
    return (lo * (64'd32768 - w) + hi * w + (64'd1 << 14)) >> 15;
  endfunction

  function automatic longint signed round_half_away(input longint signed v, input int s);
    bit              neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic gelu_result_t gelu_predict(input action_t act, input logic [15:0] x_raw,
                                                input logic [15:0] dy_raw);
    longint signed   x, dy, cdf, g, r;
    longint unsigned mag, p, idx, w, c, d;
    gelu_result_t    res;
    x   = longint'($signed(x_raw));
    dy  = longint'($signed(dy_raw));
    mag = (x < 0) ? longint'(-x) : longint'(x);
    p   = mag * SEGS;
    idx = p >> 15;
    w   = p & 64'h7FFF;
    c   = table_lerp(1'b0, idx, w);
    d   = table_lerp(1'b1, idx, w);
    cdf = (x < 0) ? longint'(Q30_ONE - c) : longint'(c);
    if (act == ACT_FORWARD) begin
      r = round_half_away(x * cdf, 30);
    end else begin
      g = (cdf << FRAC) + x * longint'(d);
      r = round_half_away(dy * g, 30 + FRAC);
    end
    res.saturated = 1'b0;
    if (r > 32767) begin
      r = 32767;
      res.saturated = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      res.saturated = 1'b1;
    end
    res.result_value = r[15:0];
    return res;
  endfunction

  initial begin
    longint unsigned acc, wsum, f, wt;
    longint unsigned den;
    acc = Q30_ONE >> 1;
    den = 3 * FINE;
    e1_q30 = exp_taylor(Q30_ONE);
    cdf_q30[0] = acc;
    for (int i = 0; i < SEGS; i++) begin
      wsum = 0;
      for (int k = 0; k <= SUBSTEPS; k++) begin
        f  = gauss_density(longint'(i * SUBSTEPS + k));
        wt = (k == 0 || k == SUBSTEPS) ? 1 : ((k % 2 == 1) ? 4 : 2);
        if (k == 0) begin
          pdf_q30[i] = f;
        end
        wsum = wsum + wt * f;
      end
      acc = acc + ((wsum << (15 - FRAC)) + den / 2) / den;
      if (acc > Q30_ONE) begin
        acc = Q30_ONE;
      end
      cdf_q30[i + 1] = acc;
    end
    pdf_q30[SEGS] = gauss_density(longint'(FINE));
  end

  always @(posedge clk) begin : watch_channels
    gelu_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(gelu_predict(action_t'(s_tuser), s_tdata[15:0],
                                                s_tdata[31:16]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: result_value %0d saturated %0b",
                 $signed(m_tdata), m_tuser);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(want.result_value), $signed(m_tdata));
            mismatch_total++;
          end
          if (m_tuser !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, m_tuser);
            mismatch_total++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ sim/gelu_forward_backward_tb.sv @@
// Stimulus, reset, clock and verdict for the GELU forward/backward stream block.
module gelu_forward_backward_tb
  import gelu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // x_value, grad_in
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // result_value
  logic        m_tuser;        // saturated
  int          failures;
  int          pending;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  gelu_forward_backward u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  gelu_forward_backward_check u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .failures (failures),
    .pending  (pending)
  );

  task automatic send_sample(input action_t act, input logic [15:0] x, input logic [15:0] dy);
    while (!quiet && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {dy, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      m_tready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    #1_000_000;
    $display("gelu_forward_backward verification failed");
    $finish;
  end

  initial begin
    int          kind;
    int          xv;
    logic [15:0] x;
    logic [15:0] dy;
    action_t     act;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_sample(ACT_FORWARD, 16'h0000, 16'($urandom));
    send_sample(ACT_FORWARD, 16'h0001, 16'h7FFF);
    send_sample(ACT_FORWARD, 16'hFFFF, 16'h8000);
    send_sample(ACT_FORWARD, 16'h7FFF, 16'($urandom));
    send_sample(ACT_FORWARD, 16'h8000, 16'h7FFF);
    send_sample(ACT_FORWARD, 16'h1000, 16'h0000);
    send_sample(ACT_FORWARD, 16'hF000, 16'($urandom));
    send_sample(ACT_FORWARD, 16'h007F, 16'hFFFF);
    send_sample(ACT_FORWARD, 16'h0080, 16'h1234);
    send_sample(ACT_FORWARD, 16'hFF7F, 16'hA5A5);
    send_sample(ACT_FORWARD, 16'd5734, 16'h8000);
    send_sample(ACT_BACKWARD, 16'h0000, 16'h7FFF);
    send_sample(ACT_BACKWARD, 16'h7FFF, 16'h7FFF);
    send_sample(ACT_BACKWARD, 16'h8000, 16'h8000);
    send_sample(ACT_BACKWARD, 16'h8000, 16'h7FFF);
    send_sample(ACT_BACKWARD, 16'd5734, 16'h7FFF);
    send_sample(ACT_BACKWARD, 16'd5734, 16'h8000);
    send_sample(ACT_BACKWARD, -16'sd5734, 16'h7FFF);
    send_sample(ACT_BACKWARD, 16'h1000, 16'h1000);
    send_sample(ACT_BACKWARD, 16'hFFFF, 16'h0001);
    send_sample(ACT_BACKWARD, 16'h0080, 16'hF000);
    send_sample(ACT_BACKWARD, 16'h0001, 16'h0000);

    for (int n = 0; n < 800; n++) begin
      quiet = (n >= 300 && n < 500);
      kind  = $urandom_range(99);
      act   = action_t'($urandom_range(1));
      dy    = 16'($urandom);
      if (kind < 40) begin
        x = 16'($urandom);
      end else if (kind < 75) begin
        xv = int'($urandom_range(32767)) - 16384;
        x  = xv[15:0];
      end else if (kind < 90) begin
        act = ACT_BACKWARD;
        xv  = 4000 + int'($urandom_range(3000));
        if ($urandom_range(1) == 1) xv = -xv;
        x  = xv[15:0];
        dy = ($urandom_range(1) == 1) ? 16'h8000 + 16'($urandom_range(2047))
                                      : 16'h7FFF - 16'($urandom_range(2047));
      end else begin
        xv = int'($urandom_range(255) << 7) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1) == 1) xv = -xv;
        x = xv[15:0];
      end
      send_sample(act, x, dy);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("gelu_forward_backward verification clean");
    end else begin
      $display("gelu_forward_backward verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gelu_pkg.sv
rtl/core/gelu_ctrl.sv
rtl/core/gelu_lookup.sv
rtl/core/gelu_product.sv
rtl/core/gelu_forward_backward.sv
sim/gelu_forward_backward_check.sv
sim/gelu_forward_backward_tb.sv
